// ===== design/assert_macros.svh =====
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, off while reset is held
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// clocked assertion that also holds during reset
`define ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/frp_pkg.sv =====
`timescale 1ns / 1ps
// shared widths, register indexes, lane types and divider step functions
// no dependencies
package frp_pkg;

	localparam int COORD_W   = 16;
	localparam int TRIG_W    = 18;
	localparam int ROT_W     = 18;
	localparam int PROD_W    = 34;
	localparam int SUM_W     = 35;
	localparam int D_W       = 19;
	localparam int NUM_W     = 34;
	localparam int DIV_W     = 20;
	localparam int QUO_W     = 17;
	localparam int SIZE_W    = 13;
	localparam int SHADE_W   = 8;
	localparam int NUM_VERT  = 3;
	localparam int NUM_LANES = 6;
	localparam int CFG_IDX_W = 3;

	localparam int SCREEN_W_DEF = 640;
	localparam int SCREEN_H_DEF = 480;

	localparam logic [CFG_IDX_W-1:0] REG_AXIS     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ANGLE    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Z = 3'd4;

	localparam logic [1:0] AXIS_X = 2'd0;
	localparam logic [1:0] AXIS_Y = 2'd1;
	localparam logic [1:0] AXIS_Z = 2'd2;

	// quarter wave polynomial coefficients, Q16
	localparam logic [16:0] SIN_A = 17'd102944;
	localparam logic [16:0] SIN_B = 17'd42048;
	localparam logic [16:0] SIN_C = 17'd4640;

	// one divider lane: remainder, divisor, dividend bits still to shift in
	typedef struct packed {
		logic [DIV_W-1:0]          rem;
		logic [DIV_W-1:0]          den;
		logic [QUO_W-1:0]          low;
		logic [QUO_W-1:0]          quo;
		logic                      neg;
		logic                      ovf;
		logic                      force_en;
		logic signed [COORD_W-1:0] force_val;
	} div_lane_t;

	typedef struct packed {
		logic [SHADE_W-1:0] shade;
		logic               err;
	} side_t;

	// set up one lane: dividend n0 + size*d over 2d, or a forced value
	function automatic div_lane_t div_prep(input logic signed [NUM_W-1:0] n0,
			input logic signed [D_W-1:0] d, input logic [SIZE_W-1:0] size);
		div_lane_t                 r;
		logic signed [NUM_W-1:0]   num;
		logic        [NUM_W-1:0]   mag;
		logic        [NUM_W-QUO_W-1:0] hi;
		logic signed [SIZE_W:0]    sz;
		sz  = $signed({1'b0, size});
		num = n0 + NUM_W'(sz) * NUM_W'(d);
		r.neg = num[NUM_W-1];
		mag = r.neg ? NUM_W'(-num) : NUM_W'(num);
		hi  = mag[NUM_W-1:QUO_W];
		r.den = {d, 1'b0};
		r.ovf = DIV_W'(hi) >= r.den;
		r.rem = r.ovf ? '0 : DIV_W'(hi);
		r.low = mag[QUO_W-1:0];
		r.quo = '0;
		r.force_en = d[D_W-1] || (d == '0);
		if (n0 > 0) begin
			r.force_val = 16'sh7FFF;
		end else if (n0 < 0) begin
			r.force_val = 16'sh8000;
		end else begin
			r.force_val = COORD_W'(size >> 1);
		end
		return r;
	endfunction

	// one restoring step, one quotient bit
	function automatic div_lane_t div_step(input div_lane_t l);
		div_lane_t        r;
		logic [DIV_W:0]   t;
		logic             ge;
		r  = l;
		t  = {l.rem, l.low[QUO_W-1]};
		ge = t >= {1'b0, l.den};
		r.rem = ge ? DIV_W'(t - {1'b0, l.den}) : t[DIV_W-1:0];
		r.low = {l.low[QUO_W-2:0], 1'b0};
		r.quo = {l.quo[QUO_W-2:0], ge};
		return r;
	endfunction

	// signed, saturated screen coordinate
	function automatic logic signed [COORD_W-1:0] div_finish(input div_lane_t l);
		logic signed [COORD_W-1:0] r;
		if (l.force_en) begin
			r = l.force_val;
		end else if (l.ovf) begin
			r = l.neg ? 16'sh8000 : 16'sh7FFF;
		end else if (!l.neg) begin
			r = (l.quo > QUO_W'(32767)) ? 16'sh7FFF : $signed(l.quo[COORD_W-1:0]);
		end else begin
			r = (l.quo > QUO_W'(32768)) ? 16'sh8000 : $signed(COORD_W'(~l.quo + 1'b1));
		end
		return r;
	endfunction

endpackage

// ===== design/face_rotate_project_top.sv =====
`timescale 1ns / 1ps
// throughput: one triangle per clock unless out_stall or the sine/cosine sequencer
// stalls input; the six 17-step dividers are fully pipelined
// a write of the angle register runs the sine/cosine sequencer, input stalls meanwhile
// reset (arst_n low, asynchronous) empties the pipeline and loads register defaults:
// axis y, angle 0 (cosine one, sine zero), offsets 0, 0 and 5.0
// depends on frp_pkg
module face_rotate_project_top #(
	parameter int SCREEN_W = frp_pkg::SCREEN_W_DEF,
	parameter int SCREEN_H = frp_pkg::SCREEN_H_DEF
) (
	input  logic clk,
	input  logic arst_n,

	// configuration write port
	input  logic                            cfg_we,
	input  logic [frp_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [frp_pkg::COORD_W-1:0]     cfg_data,

	// input channel: one triangle per beat
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic signed [frp_pkg::COORD_W-1:0] a_x,
	input  logic signed [frp_pkg::COORD_W-1:0] a_y,
	input  logic signed [frp_pkg::COORD_W-1:0] a_z,
	input  logic signed [frp_pkg::COORD_W-1:0] b_x,
	input  logic signed [frp_pkg::COORD_W-1:0] b_y,
	input  logic signed [frp_pkg::COORD_W-1:0] b_z,
	input  logic signed [frp_pkg::COORD_W-1:0] c_x,
	input  logic signed [frp_pkg::COORD_W-1:0] c_y,
	input  logic signed [frp_pkg::COORD_W-1:0] c_z,

	// output channel: projected triangle
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic signed [frp_pkg::COORD_W-1:0] a_screen_x,
	output logic signed [frp_pkg::COORD_W-1:0] a_screen_y,
	output logic signed [frp_pkg::COORD_W-1:0] b_screen_x,
	output logic signed [frp_pkg::COORD_W-1:0] b_screen_y,
	output logic signed [frp_pkg::COORD_W-1:0] c_screen_x,
	output logic signed [frp_pkg::COORD_W-1:0] c_screen_y,
	output logic [frp_pkg::SHADE_W-1:0]     depth_shade,
	output logic                            depth_error
);

	localparam int QW  = frp_pkg::QUO_W;
	// stage slots: s1 products, s2 rotated, divider setup, QW divider steps, output
	localparam int NST = QW + 4;
	localparam int CW  = frp_pkg::COORD_W;

	// sequencer codes for the sine/cosine unit
	localparam logic [2:0] TS_IDLE   = 3'd0;
	localparam logic [2:0] TS_SQUARE = 3'd1;
	localparam logic [2:0] TS_INNER  = 3'd2;
	localparam logic [2:0] TS_MID    = 3'd3;
	localparam logic [2:0] TS_OUTER  = 3'd4;

	// ---------------------------------------------------------------
	// configuration registers
	// ---------------------------------------------------------------
	logic [1:0]            axis_q;
	logic [CW-1:0]         angle_q;
	logic signed [CW-1:0]  off_x_q;
	logic signed [CW-1:0]  off_y_q;
	logic signed [CW-1:0]  off_z_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axis_q  <= frp_pkg::AXIS_Y;
			angle_q <= '0;
			off_x_q <= '0;
			off_y_q <= '0;
			off_z_q <= 16'sd1280;
		end else if (cfg_we) begin
			unique case (cfg_index)
				frp_pkg::REG_AXIS:     axis_q  <= cfg_data[1:0];
				frp_pkg::REG_ANGLE:    angle_q <= cfg_data;
				frp_pkg::REG_OFFSET_X: off_x_q <= $signed(cfg_data);
				frp_pkg::REG_OFFSET_Y: off_y_q <= $signed(cfg_data);
				frp_pkg::REG_OFFSET_Z: off_z_q <= $signed(cfg_data);
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------
	// sine/cosine sequencer: two lanes (angle and its complement in the
	// quadrant), one multiplier each, four steps: a square, then the Horner steps
	// ---------------------------------------------------------------
	logic [2:0]  trig_step_q;
	logic [14:0] tv_q [2];
	logic [14:0] z2_q [2];
	logic [16:0] acc_q [2];
	logic signed [frp_pkg::TRIG_W-1:0] cos_q;
	logic signed [frp_pkg::TRIG_W-1:0] sin_q;

	logic [16:0] mul_a [2];
	logic [14:0] mul_b [2];
	logic [31:0] mul_p [2];
	logic [17:0] mul_sh [2];

	always_comb begin
		for (int l = 0; l < 2; l++) begin
			unique case (trig_step_q)
				TS_SQUARE: begin
					mul_a[l] = 17'(tv_q[l]);
					mul_b[l] = tv_q[l];
				end
				TS_INNER: begin
					mul_a[l] = frp_pkg::SIN_C;
					mul_b[l] = z2_q[l];
				end
				TS_MID: begin
					mul_a[l] = frp_pkg::SIN_B - acc_q[l];
					mul_b[l] = z2_q[l];
				end
				TS_OUTER: begin
					mul_a[l] = frp_pkg::SIN_A - acc_q[l];
					mul_b[l] = tv_q[l];
				end
				default: begin
					mul_a[l] = '0;
					mul_b[l] = '0;
				end
			endcase
			mul_p[l]  = 32'(mul_a[l]) * 32'(mul_b[l]);
			mul_sh[l] = mul_p[l][31:14];
		end
	end

	logic signed [frp_pkg::TRIG_W-1:0] sr_w;
	logic signed [frp_pkg::TRIG_W-1:0] sc_w;
	assign sr_w = $signed({1'b0, mul_sh[0][16:0]});
	assign sc_w = $signed({1'b0, mul_sh[1][16:0]});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trig_step_q <= TS_IDLE;
			cos_q       <= 18'sd65536;
			sin_q       <= '0;
		end else if (cfg_we && cfg_index == frp_pkg::REG_ANGLE) begin
			trig_step_q <= TS_SQUARE;
		end else begin
			unique case (trig_step_q)
				TS_SQUARE: trig_step_q <= TS_INNER;
				TS_INNER:  trig_step_q <= TS_MID;
				TS_MID:    trig_step_q <= TS_OUTER;
				TS_OUTER: begin
					trig_step_q <= TS_IDLE;
					// fold the quarter wave into the angle's quadrant
					unique case (angle_q[15:14])
						2'd0: begin sin_q <= sr_w;  cos_q <= sc_w;  end
						2'd1: begin sin_q <= sc_w;  cos_q <= -sr_w; end
						2'd2: begin sin_q <= -sr_w; cos_q <= -sc_w; end
						default: begin sin_q <= -sc_w; cos_q <= sr_w; end
					endcase
				end
				default: trig_step_q <= TS_IDLE;
			endcase
		end
	end

	// lane data, no reset needed
	always_ff @(posedge clk) begin
		if (cfg_we && cfg_index == frp_pkg::REG_ANGLE) begin
			tv_q[0] <= {1'b0, cfg_data[13:0]};
			tv_q[1] <= 15'd16384 - {1'b0, cfg_data[13:0]};
		end else begin
			for (int l = 0; l < 2; l++) begin
				unique case (trig_step_q)
					TS_SQUARE: z2_q[l] <= mul_sh[l][14:0];
					TS_INNER:  acc_q[l] <= mul_sh[l][16:0];
					TS_MID:    acc_q[l] <= mul_sh[l][16:0];
					default: ;
				endcase
			end
		end
	end

	logic trig_busy;
	assign trig_busy = trig_step_q != TS_IDLE;

	// ---------------------------------------------------------------
	// pipeline control: valid bits per slot, bubbles collapse
	// ---------------------------------------------------------------
	logic [NST-1:0] v_q;
	logic [NST:0]   rdy;

	always_comb begin
		rdy[NST] = !out_stall;
		for (int i = NST - 1; i >= 0; i--) begin
			rdy[i] = !v_q[i] || rdy[i+1];
		end
	end

	assign in_stall = !rdy[0] || trig_busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (rdy[0]) begin
				v_q[0] <= in_valid && !trig_busy;
			end
			for (int i = 1; i < NST; i++) begin
				if (rdy[i]) begin
					v_q[i] <= v_q[i-1];
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// s1: pick the rotated plane for the axis, four products per vertex
	// ---------------------------------------------------------------
	logic signed [CW-1:0] vx [frp_pkg::NUM_VERT];
	logic signed [CW-1:0] vy [frp_pkg::NUM_VERT];
	logic signed [CW-1:0] vz [frp_pkg::NUM_VERT];

	assign vx[0] = a_x;
	assign vy[0] = a_y;
	assign vz[0] = a_z;
	assign vx[1] = b_x;
	assign vy[1] = b_y;
	assign vz[1] = b_z;
	assign vx[2] = c_x;
	assign vy[2] = c_y;
	assign vz[2] = c_z;

	logic signed [CW-1:0] u_w [frp_pkg::NUM_VERT];
	logic signed [CW-1:0] w_w [frp_pkg::NUM_VERT];

	always_comb begin
		for (int k = 0; k < frp_pkg::NUM_VERT; k++) begin
			unique case (axis_q)
				frp_pkg::AXIS_X: begin u_w[k] = vy[k]; w_w[k] = vz[k]; end
				frp_pkg::AXIS_Y: begin u_w[k] = vx[k]; w_w[k] = vz[k]; end
				default:         begin u_w[k] = vx[k]; w_w[k] = vy[k]; end
			endcase
		end
	end

	logic signed [frp_pkg::PROD_W-1:0] uc_s1 [frp_pkg::NUM_VERT];
	logic signed [frp_pkg::PROD_W-1:0] ws_s1 [frp_pkg::NUM_VERT];
	logic signed [frp_pkg::PROD_W-1:0] us_s1 [frp_pkg::NUM_VERT];
	logic signed [frp_pkg::PROD_W-1:0] wc_s1 [frp_pkg::NUM_VERT];
	logic signed [CW-1:0] x_s1 [frp_pkg::NUM_VERT];
	logic signed [CW-1:0] y_s1 [frp_pkg::NUM_VERT];
	logic signed [CW-1:0] z_s1 [frp_pkg::NUM_VERT];

	always_ff @(posedge clk) begin
		if (rdy[0]) begin
			for (int k = 0; k < frp_pkg::NUM_VERT; k++) begin
				uc_s1[k] <= frp_pkg::PROD_W'(u_w[k]) * frp_pkg::PROD_W'(cos_q);
				ws_s1[k] <= frp_pkg::PROD_W'(w_w[k]) * frp_pkg::PROD_W'(sin_q);
				us_s1[k] <= frp_pkg::PROD_W'(u_w[k]) * frp_pkg::PROD_W'(sin_q);
				wc_s1[k] <= frp_pkg::PROD_W'(w_w[k]) * frp_pkg::PROD_W'(cos_q);
				x_s1[k]  <= vx[k];
				y_s1[k]  <= vy[k];
				z_s1[k]  <= vz[k];
			end
		end
	end

	// ---------------------------------------------------------------
	// s2: sum, round to Q9.8 (floor of half-up), map back onto x/y/z
	// ---------------------------------------------------------------
	logic signed [frp_pkg::SUM_W-1:0] p_sum [frp_pkg::NUM_VERT];
	logic signed [frp_pkg::SUM_W-1:0] q_sum [frp_pkg::NUM_VERT];
	logic signed [frp_pkg::ROT_W-1:0] p_rnd [frp_pkg::NUM_VERT];
	logic signed [frp_pkg::ROT_W-1:0] q_rnd [frp_pkg::NUM_VERT];
	logic signed [frp_pkg::ROT_W-1:0] rx_w [frp_pkg::NUM_VERT];
	logic signed [frp_pkg::ROT_W-1:0] ry_w [frp_pkg::NUM_VERT];
	logic signed [frp_pkg::ROT_W-1:0] rz_w [frp_pkg::NUM_VERT];

	always_comb begin
		for (int k = 0; k < frp_pkg::NUM_VERT; k++) begin
			p_sum[k] = frp_pkg::SUM_W'(uc_s1[k]) - frp_pkg::SUM_W'(ws_s1[k])
				+ 35'sd32768;
			q_sum[k] = frp_pkg::SUM_W'(us_s1[k]) + frp_pkg::SUM_W'(wc_s1[k])
				+ 35'sd32768;
			p_rnd[k] = p_sum[k][frp_pkg::ROT_W+15:16];
			q_rnd[k] = q_sum[k][frp_pkg::ROT_W+15:16];
			rx_w[k]  = frp_pkg::ROT_W'(x_s1[k]);
			ry_w[k]  = frp_pkg::ROT_W'(y_s1[k]);
			rz_w[k]  = frp_pkg::ROT_W'(z_s1[k]);
			unique case (axis_q)
				frp_pkg::AXIS_X: begin
					ry_w[k] = p_rnd[k];
					rz_w[k] = q_rnd[k];
				end
				frp_pkg::AXIS_Y: begin
					rx_w[k] = p_rnd[k];
					rz_w[k] = q_rnd[k];
				end
				frp_pkg::AXIS_Z: begin
					rx_w[k] = p_rnd[k];
					ry_w[k] = q_rnd[k];
				end
				// axis code three: no rotation
				default: ;
			endcase
		end
	end

	logic signed [frp_pkg::ROT_W-1:0] rx_s2 [frp_pkg::NUM_VERT];
	logic signed [frp_pkg::ROT_W-1:0] ry_s2 [frp_pkg::NUM_VERT];
	logic signed [frp_pkg::ROT_W-1:0] rz_s2 [frp_pkg::NUM_VERT];

	always_ff @(posedge clk) begin
		if (rdy[1]) begin
			for (int k = 0; k < frp_pkg::NUM_VERT; k++) begin
				rx_s2[k] <= rx_w[k];
				ry_s2[k] <= ry_w[k];
				rz_s2[k] <= rz_w[k];
			end
		end
	end

	// ---------------------------------------------------------------
	// divider setup: offsets, depth, dividends, forced values, shade
	// ---------------------------------------------------------------
	frp_pkg::div_lane_t dv_s [QW+1][frp_pkg::NUM_LANES];
	frp_pkg::side_t     side_s [QW+1];

	logic signed [frp_pkg::D_W-1:0]   ax_w [frp_pkg::NUM_VERT];
	logic signed [frp_pkg::D_W-1:0]   ay_w [frp_pkg::NUM_VERT];
	logic signed [frp_pkg::D_W-1:0]   d_w  [frp_pkg::NUM_VERT];
	logic signed [frp_pkg::NUM_W-1:0] nx_w [frp_pkg::NUM_VERT];
	logic signed [frp_pkg::NUM_W-1:0] ny_w [frp_pkg::NUM_VERT];
	frp_pkg::div_lane_t               prep_w [frp_pkg::NUM_LANES];

	always_comb begin
		for (int k = 0; k < frp_pkg::NUM_VERT; k++) begin
			ax_w[k] = frp_pkg::D_W'(rx_s2[k]) + frp_pkg::D_W'(off_x_q);
			ay_w[k] = frp_pkg::D_W'(ry_s2[k]) + frp_pkg::D_W'(off_y_q);
			d_w[k]  = frp_pkg::D_W'(rz_s2[k]) + frp_pkg::D_W'(off_z_q);
			nx_w[k] = frp_pkg::NUM_W'(ax_w[k]) * 34'sd400;
			ny_w[k] = -(frp_pkg::NUM_W'(ay_w[k]) * 34'sd400);
			prep_w[2*k]   = frp_pkg::div_prep(nx_w[k], d_w[k],
				frp_pkg::SIZE_W'(SCREEN_W));
			prep_w[2*k+1] = frp_pkg::div_prep(ny_w[k], d_w[k],
				frp_pkg::SIZE_W'(SCREEN_H));
		end
	end

	// shade = 255 * (1280 - z) / 2560, clamped; /2560 as >>9 then *52429>>18 for /5
	logic signed [frp_pkg::ROT_W:0] shade_diff;
	logic signed [27:0]             shade_n;
	logic [10:0]                    shade_m;
	logic [26:0]                    shade_p;
	logic [frp_pkg::SHADE_W-1:0]    shade_w;
	logic                           err_w;

	always_comb begin
		shade_diff = 19'sd1280 - (frp_pkg::ROT_W+1)'(rz_s2[0]);
		shade_n    = 28'(shade_diff) * 28'sd255;
		shade_m    = shade_n[19:9];
		shade_p    = 27'(shade_m) * 27'd52429;
		if (shade_n <= 0) begin
			shade_w = '0;
		end else if (shade_n >= 28'sd655360) begin
			shade_w = 8'd255;
		end else begin
			shade_w = shade_p[25:18];
		end
		err_w = 1'b0;
		for (int l = 0; l < frp_pkg::NUM_LANES; l++) begin
			err_w = err_w | prep_w[l].force_en;
		end
	end

	// ---------------------------------------------------------------
	// divider: setup slot, then one quotient bit per stage, six lanes side by side
	// ---------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (rdy[2]) begin
			for (int l = 0; l < frp_pkg::NUM_LANES; l++) begin
				dv_s[0][l] <= prep_w[l];
			end
			side_s[0].shade <= shade_w;
			side_s[0].err   <= err_w;
		end
		for (int g = 1; g <= QW; g++) begin
			if (rdy[2+g]) begin
				for (int l = 0; l < frp_pkg::NUM_LANES; l++) begin
					dv_s[g][l] <= frp_pkg::div_step(dv_s[g-1][l]);
				end
				side_s[g] <= side_s[g-1];
			end
		end
	end

	// ---------------------------------------------------------------
	// output register: sign, saturation, forced values
	// ---------------------------------------------------------------
	logic signed [CW-1:0]        scr_q [frp_pkg::NUM_LANES];
	logic [frp_pkg::SHADE_W-1:0] shade_q;
	logic                        err_q;

	always_ff @(posedge clk) begin
		if (rdy[NST-1]) begin
			for (int l = 0; l < frp_pkg::NUM_LANES; l++) begin
				scr_q[l] <= frp_pkg::div_finish(dv_s[QW][l]);
			end
			shade_q <= side_s[QW].shade;
			err_q   <= side_s[QW].err;
		end
	end

	assign out_valid   = v_q[NST-1];
	assign a_screen_x  = scr_q[0];
	assign a_screen_y  = scr_q[1];
	assign b_screen_x  = scr_q[2];
	assign b_screen_y  = scr_q[3];
	assign c_screen_x  = scr_q[4];
	assign c_screen_y  = scr_q[5];
	assign depth_shade = shade_q;
	assign depth_error = err_q;

endmodule

// ===== design/frp_checker.sv =====
`timescale 1ns / 1ps
// port-level checks for the face rotate/project block, bound to the top level
// depends on frp_pkg and assert_macros.svh
`include "assert_macros.svh"

module frp_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              cfg_we,
	input logic [frp_pkg::CFG_IDX_W-1:0]     cfg_index,
	input logic                              in_stall,
	input logic                              out_valid,
	input logic                              out_stall,
	input logic signed [frp_pkg::COORD_W-1:0] a_screen_x,
	input logic                              depth_error
);

	// a stalled output beat stays
	`ASSERT_CLK(a_out_hold, out_valid && out_stall |=> out_valid, "output beat dropped")

	// and keeps its payload
	`ASSERT_CLK(a_out_stable, out_valid && out_stall |=> $stable(a_screen_x) && $stable(depth_error), "stalled payload changed")

	// angle write starts the trig sequencer, which holds off input
	`ASSERT_CLK(a_angle_stall, cfg_we && cfg_index == frp_pkg::REG_ANGLE |=> in_stall, "input taken during trig update")

	// nothing comes out while reset is held
	`ASSERT_ALWAYS(a_rst_quiet, !arst_n |-> !out_valid, "output valid in reset")

endmodule

bind face_rotate_project_top frp_checker u_frp_checker (.*);

// ===== test/face_rotate_project_top_tb.sv =====
`timescale 1ns / 1ps
// self-checking bench for face_rotate_project_top: random and directed triangles,
// register writes between phases, results checked against a local projection model
// depends on frp_pkg and face_rotate_project_top
module face_rotate_project_top_tb;

	localparam int SCR_W = 640;
	localparam int SCR_H = 480;
	localparam int DRAIN_CYCLES = 40;
	localparam int STALL_LIMIT = 5000;

	// one triangle beat
	typedef struct {
		logic signed [15:0] v[9];
	} tri_t;

	// one projected triangle
	typedef struct {
		logic signed [15:0] scr[6];
		logic [7:0]         shade;
		logic               err;
	} proj_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we = 1'b0;
	logic [frp_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [frp_pkg::COORD_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [15:0] vin[9] = '{default: '0};
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [15:0] a_screen_x, a_screen_y, b_screen_x, b_screen_y;
	logic signed [15:0] c_screen_x, c_screen_y;
	logic [7:0] depth_shade;
	logic depth_error;

	string scr_names[6] = '{"a_screen_x", "a_screen_y", "b_screen_x", "b_screen_y",
		"c_screen_x", "c_screen_y"};

	// model copy of the registers and the sine/cosine state
	logic [1:0]         m_axis;
	logic [15:0]        m_angle;
	logic signed [15:0] m_ox, m_oy, m_oz;
	longint             m_cos, m_sin;

	tri_t  tri_q[$];
	proj_t proj_q[$];
	int    fail_cnt = 0;
	int    idle_cnt = 0;
	int    idle_pct = 24;
	bit    done_feed = 1'b0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	face_rotate_project_top u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.a_x(vin[0]), .a_y(vin[1]), .a_z(vin[2]),
		.b_x(vin[3]), .b_y(vin[4]), .b_z(vin[5]),
		.c_x(vin[6]), .c_y(vin[7]), .c_z(vin[8]),
		.out_valid(out_valid), .out_stall(out_stall),
		.a_screen_x(a_screen_x), .a_screen_y(a_screen_y),
		.b_screen_x(b_screen_x), .b_screen_y(b_screen_y),
		.c_screen_x(c_screen_x), .c_screen_y(c_screen_y),
		.depth_shade(depth_shade), .depth_error(depth_error)
	);

	// quarter sine wave, q14 phase in, q16 out
	function automatic longint qsine(longint t);
		longint z2, inner, t2;
		z2 = (t * t) >>> 14;
		inner = (4640 * z2) >>> 14;
		t2 = ((42048 - inner) * z2) >>> 14;
		return ((102944 - t2) * t) >>> 14;
	endfunction

	function automatic void trig_update();
		longint sr, sc;
		sr = qsine(longint'(m_angle[13:0]));
		sc = qsine(16384 - longint'(m_angle[13:0]));
		case (m_angle[15:14])
			2'd0: begin m_sin = sr; m_cos = sc; end
			2'd1: begin m_sin = sc; m_cos = -sr; end
			2'd2: begin m_sin = -sr; m_cos = -sc; end
			default: begin m_sin = -sc; m_cos = sr; end
		endcase
	endfunction

	// floor((v + 32768) / 65536)
	function automatic longint round_q8(longint v);
		return (v + 32768) >>> 16;
	endfunction

	function automatic logic signed [15:0] screen_coord(longint num, longint d,
			longint size, inout logic err);
		longint q;
		if (d <= 0) begin
			err = 1'b1;
			if (num > 0) return 16'sh7FFF;
			if (num < 0) return 16'sh8000;
			return 16'(size / 2);
		end
		q = (2 * num + size * d) / (2 * d);
		if (q > 32767) return 16'sh7FFF;
		if (q < -32768) return 16'sh8000;
		return 16'(q);
	endfunction

	function automatic proj_t project_triangle(tri_t t);
		proj_t  p;
		longint x, y, z, rx, ry, rz, first_z, n;
		logic   err;
		err = 1'b0;
		first_z = 0;
		for (int k = 0; k < 3; k++) begin
			x = t.v[3*k]; y = t.v[3*k+1]; z = t.v[3*k+2];
			rx = x; ry = y; rz = z;
			case (m_axis)
				frp_pkg::AXIS_X: begin
					ry = round_q8(y * m_cos - z * m_sin);
					rz = round_q8(y * m_sin + z * m_cos);
				end
				frp_pkg::AXIS_Y: begin
					rx = round_q8(x * m_cos - z * m_sin);
					rz = round_q8(x * m_sin + z * m_cos);
				end
				frp_pkg::AXIS_Z: begin
					rx = round_q8(x * m_cos - y * m_sin);
					ry = round_q8(x * m_sin + y * m_cos);
				end
				default: ;
			endcase
			if (k == 0) first_z = rz;
			p.scr[2*k] = screen_coord(200 * (rx + m_ox), rz + m_oz, SCR_W, err);
			p.scr[2*k+1] = screen_coord(-200 * (ry + m_oy), rz + m_oz, SCR_H, err);
		end
		n = 255 * (1280 - first_z);
		if (n <= 0) p.shade = 8'd0;
		else if (n / 2560 > 255) p.shade = 8'd255;
		else p.shade = 8'(n / 2560);
		p.err = err;
		return p;
	endfunction

	// driver: pops the pending queue, predicts each accepted beat
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				proj_q.push_back(project_triangle(tri_q.pop_front()));
			end
			// valid stays up while stalled; the queue front is the next beat
			if (!(in_valid && in_stall)) begin
				if (tri_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
					tri_t nxt;
					nxt = tri_q[0];
					for (int i = 0; i < 9; i++) vin[i] <= nxt.v[i];
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: compares each accepted result beat with the oldest prediction
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (proj_q.size() == 0) begin
					$error("result beat with no prediction waiting");
					fail_cnt++;
				end else begin
					proj_t e;
					logic signed [15:0] got[6];
					e = proj_q.pop_front();
					got = '{a_screen_x, a_screen_y, b_screen_x, b_screen_y,
						c_screen_x, c_screen_y};
					for (int i = 0; i < 6; i++) begin
						if (got[i] !== e.scr[i]) begin
							$error("%s: expected %0d, got %0d", scr_names[i], e.scr[i],
								got[i]);
							fail_cnt++;
						end
					end
					if (depth_shade !== e.shade) begin
						$error("depth_shade: expected %0d, got %0d", e.shade, depth_shade);
						fail_cnt++;
					end
					if (depth_error !== e.err) begin
						$error("depth_error: expected %0d, got %0d", e.err, depth_error);
						fail_cnt++;
					end
				end
			end
			out_stall <= ($urandom_range(99) < idle_pct);
		end
	end

	// watchdog on cycles with no accepted beat
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || !arst_n || cfg_we) begin
			idle_cnt <= 0;
		end else if (idle_cnt >= STALL_LIMIT && !(done_feed && proj_q.size() == 0)) begin
			$display("face_rotate_project_top regression: fail");
			$finish;
		end else begin
			idle_cnt <= idle_cnt + 1;
		end
	end

	function automatic logic signed [15:0] rnd_coord();
		case ($urandom_range(5))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			2: return 16'($urandom);
			default: return 16'($signed($urandom_range(2560)) - 1280);
		endcase
	endfunction

	task automatic add_tri(logic signed [15:0] a, logic signed [15:0] b);
		tri_t t;
		for (int i = 0; i < 9; i++) t.v[i] = (i % 2) ? b : a;
		tri_q.push_back(t);
	endtask

	task automatic add_random(int n);
		tri_t t;
		repeat (n) begin
			for (int i = 0; i < 9; i++) t.v[i] = rnd_coord();
			tri_q.push_back(t);
		end
	endtask

	// wait for the pipeline to drain fully before touching registers
	task automatic wait_idle();
		while (tri_q.size() != 0 || in_valid || proj_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [frp_pkg::CFG_IDX_W-1:0] idx, logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			frp_pkg::REG_AXIS: m_axis = val[1:0];
			frp_pkg::REG_ANGLE: begin m_angle = val; trig_update(); end
			frp_pkg::REG_OFFSET_X: m_ox = val;
			frp_pkg::REG_OFFSET_Y: m_oy = val;
			frp_pkg::REG_OFFSET_Z: m_oz = val;
			default: ;
		endcase
		// let the sine/cosine sequencer settle
		repeat (8) @(posedge clk);
	endtask

	initial begin
		logic [15:0] angles[6];
		arst_n = 1'b0;
		angles = '{16'd0, 16'd16384, 16'd32768, 16'd49152, 16'd65535, 16'd5000};
		m_axis = frp_pkg::AXIS_Y; m_angle = '0; m_ox = '0; m_oy = '0; m_oz = 16'sd1280;
		trig_update();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, zero depth, negative depth, all at reset defaults
		add_tri(16'sh0000, 16'sh0000);
		add_tri(16'sh7FFF, 16'sh8000);
		add_tri(16'sh8000, 16'sh7FFF);
		add_tri(16'sh7FFF, 16'sh7FFF);
		add_tri(16'sh8000, 16'sh8000);
		add_tri(16'shFB00, 16'sh0100);
		add_tri(16'shFA00, 16'shFF00);
		add_tri(16'sh0100, 16'shFFFF);
		add_tri(16'shAAAA, 16'sh5555);
		add_random(10);
		wait_idle();

		// each axis, including the pass-through code, at several angles
		for (int ph = 0; ph < 12; ph++) begin
			write_reg(frp_pkg::REG_AXIS, 16'(ph % 4));
			write_reg(frp_pkg::REG_ANGLE, (ph < 6) ? angles[ph] : 16'($urandom));
			write_reg(frp_pkg::REG_OFFSET_X, (ph == 1) ? 16'h7FFF : (ph == 2) ? 16'h8000 :
				16'($urandom));
			write_reg(frp_pkg::REG_OFFSET_Y, (ph == 3) ? 16'h7FFF : (ph == 4) ? 16'h8000 :
				16'($urandom));
			write_reg(frp_pkg::REG_OFFSET_Z, (ph == 5) ? 16'h0000 : (ph == 6) ? 16'h7FFF :
				(ph == 7) ? 16'h8000 : 16'($urandom_range(4000)));
			// one phase without any idling on either side
			idle_pct = (ph == 8) ? 0 : 24;
			add_random(85);
			wait_idle();
		end
		done_feed = 1'b1;
		if (fail_cnt == 0 && proj_q.size() == 0) begin
			$display("face_rotate_project_top regression: pass");
		end else begin
			$display("face_rotate_project_top regression: fail");
		end
		$finish;
	end

endmodule
